@@ sv/hrpi_pkg.sv @@
// ----------------------------------------------------------------------------
// hrpi_pkg: shared types and constants for the heart rate peak interval core
// Holds the detector phase codes, rate limits and the divider handshake type.
// ----------------------------------------------------------------------------
package hrpi_pkg;

  // Detector phase, as kept between samples.
  typedef enum logic [1:0] {
    PH_ZERO_CROSS = 2'd0,
    PH_PEAK       = 2'd1,
    PH_COMPUTE    = 2'd2
  } phase_t;

  // Rate arithmetic: beats per minute is RATE_NUM divided by the interval in ms.
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned CNT_W    = $clog2(NUM_W);
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 9;
  localparam int unsigned THRESH_W = 16;

  localparam logic [NUM_W-1:0] RATE_NUM     = NUM_W'(60000);
  localparam logic [NUM_W-1:0] RATE_LO_EXCL = NUM_W'(30);
  localparam logic [NUM_W-1:0] RATE_HI_EXCL = NUM_W'(280);

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(20);

  // Configuration register word indexes.
  localparam logic REG_PEAK_THRESHOLD = 1'b0;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ sv/hrpi_div.sv @@
// ----------------------------------------------------------------------------
// hrpi_div: iterative restoring divider for the rate computation
// Divides the fixed numerator by a 32-bit interval, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module hrpi_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [hrpi_pkg::TIME_W-1:0]       divisor,
  output hrpi_pkg::div_stat_t               stat,
  output logic [hrpi_pkg::NUM_W-1:0]        quotient
);

  logic [hrpi_pkg::TIME_W-1:0] dvs_r;
  logic [hrpi_pkg::NUM_W-1:0]  rem_r, rem_nxt;
  logic [hrpi_pkg::NUM_W-1:0]  quo_r, quo_nxt;
  logic [hrpi_pkg::CNT_W-1:0]  cnt_r;
  logic                        busy_r;
  logic                        done_r;

  // One trial subtraction: shift the next numerator bit into the remainder.
  logic [hrpi_pkg::NUM_W:0]    trial;
  logic                        fits;
  logic [hrpi_pkg::NUM_W:0]    diff;

  always_comb begin
    trial   = {rem_r, quo_r[hrpi_pkg::NUM_W-1]};
    fits    = {{(hrpi_pkg::TIME_W-hrpi_pkg::NUM_W-1){1'b0}}, trial} >= dvs_r;
    diff    = trial - dvs_r[hrpi_pkg::NUM_W:0];
    rem_nxt = fits ? diff[hrpi_pkg::NUM_W-1:0] : trial[hrpi_pkg::NUM_W-1:0];
    quo_nxt = {quo_r[hrpi_pkg::NUM_W-2:0], fits};
  end

  // Step counter and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvs_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= hrpi_pkg::RATE_NUM;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {hrpi_pkg::CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ sv/heart_rate_peak_interval_core.sv @@
// ----------------------------------------------------------------------------
// heart_rate_peak_interval_core: pulse peak interval to heart rate
// Finds falling peaks after upward zero crossings and reports 60000 / interval.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                              Transfer when
//  in       input      in_sample, in_timestamp_ms           in_valid && !in_stall
//  out      output     out_beat_found, out_rate_bpm         out_valid && !out_stall
//  cfg      APB slave  cfg_psel/penable/pwrite/paddr/pwdata psel && penable && pwrite
//
//  Detection items finish in the cycle they are accepted; a compute item waits
//  for the 16 steps of the restoring divider.
//  Reset is synchronous on rst_n and restores the threshold to 20.
//  A result waits in the output register; the next item is taken once the
//  sequencer is idle and that register is free or being read in the same cycle.
// ----------------------------------------------------------------------------
module heart_rate_peak_interval_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Sample channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample,
  input  logic [hrpi_pkg::TIME_W-1:0]      in_timestamp_ms,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_beat_found,
  output logic [hrpi_pkg::RATE_W-1:0]      out_rate_bpm,
  // Configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  // Compare width holds both the sample and the threshold with a spare sign bit.
  localparam int CW = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                              state_r, state_nxt;
  hrpi_pkg::phase_t                    phase_r, phase_nxt;
  logic signed [SAMPLE_WIDTH-1:0]      prev_r, prev_nxt;
  logic                                peaks_r, peaks_nxt;
  logic [hrpi_pkg::TIME_W-1:0]         first_r, first_nxt;
  logic [hrpi_pkg::TIME_W-1:0]         second_r, second_nxt;
  logic [hrpi_pkg::THRESH_W-1:0]       thresh_r;
  logic                                out_valid_r, out_valid_nxt;
  logic                                beat_r, beat_nxt;
  logic [hrpi_pkg::RATE_W-1:0]         rate_r, rate_nxt;

  logic                                out_free;
  logic                                in_xfer;
  logic                                cfg_wr;
  logic                                div_start;
  logic [hrpi_pkg::TIME_W-1:0]         interval;
  hrpi_pkg::div_stat_t                 div_stat;
  logic [hrpi_pkg::NUM_W-1:0]          div_quo;
  logic                                q_ok;
  logic [hrpi_pkg::RATE_W-1:0]         q_rate;

  logic signed [CW-1:0]                s_ext, prev_ext, thr_ext;
  logic                                s_pos;
  logic                                is_peak;

  // Handshake.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;

  // Configuration port: one word, selected by the word address bit.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == hrpi_pkg::REG_PEAK_THRESHOLD);
  assign cfg_prdata = (cfg_paddr[2] == hrpi_pkg::REG_PEAK_THRESHOLD) ?
                      {{(32-hrpi_pkg::THRESH_W){thresh_r[hrpi_pkg::THRESH_W-1]}}, thresh_r} :
                      32'd0;

  // Signed comparisons against threshold and previous sample.
  assign s_ext    = {{(CW-SAMPLE_WIDTH){in_sample[SAMPLE_WIDTH-1]}}, in_sample};
  assign prev_ext = {{(CW-SAMPLE_WIDTH){prev_r[SAMPLE_WIDTH-1]}}, prev_r};
  assign thr_ext  = {{(CW-hrpi_pkg::THRESH_W){thresh_r[hrpi_pkg::THRESH_W-1]}}, thresh_r};
  assign s_pos    = !s_ext[CW-1] && (s_ext != '0);
  assign is_peak  = (s_ext > thr_ext) && (s_ext < prev_ext);

  // Interval between the two held peaks, modulo 2^32.
  assign interval = second_r - first_r;

  // Range check of the divider quotient.
  assign q_ok   = (div_quo > hrpi_pkg::RATE_LO_EXCL) && (div_quo < hrpi_pkg::RATE_HI_EXCL);
  assign q_rate = q_ok ? div_quo[hrpi_pkg::RATE_W-1:0] : '0;

  hrpi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (interval),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Sequencer and detector next state.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    prev_nxt      = prev_r;
    peaks_nxt     = peaks_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    beat_nxt      = beat_r;
    rate_nxt      = rate_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (phase_r)
            hrpi_pkg::PH_PEAK: begin
              if (is_peak) begin
                if (!peaks_r) begin
                  first_nxt = in_timestamp_ms;
                  peaks_nxt = 1'b1;
                  phase_nxt = hrpi_pkg::PH_ZERO_CROSS;
                end else begin
                  second_nxt = in_timestamp_ms;
                  phase_nxt  = hrpi_pkg::PH_COMPUTE;
                end
              end
              prev_nxt      = in_sample;
              beat_nxt      = 1'b0;
              rate_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            hrpi_pkg::PH_COMPUTE: begin
              // Restart with the second peak as the first of the next pair.
              phase_nxt = hrpi_pkg::PH_ZERO_CROSS;
              peaks_nxt = 1'b1;
              prev_nxt  = '0;
              first_nxt = second_r;
              if (interval == '0) begin
                beat_nxt      = 1'b0;
                rate_nxt      = '0;
                out_valid_nxt = 1'b1;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            default: begin
              phase_nxt     = (s_pos && prev_r[SAMPLE_WIDTH-1]) ?
                              hrpi_pkg::PH_PEAK : hrpi_pkg::PH_ZERO_CROSS;
              prev_nxt      = in_sample;
              beat_nxt      = 1'b0;
              rate_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            beat_nxt      = q_ok;
            rate_nxt      = q_rate;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        // The divider holds its quotient until the next start.
        if (out_free) begin
          beat_nxt      = q_ok;
          rate_nxt      = q_rate;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, detector history and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= hrpi_pkg::PH_ZERO_CROSS;
      prev_r      <= '0;
      peaks_r     <= 1'b0;
      first_r     <= '0;
      second_r    <= '0;
      thresh_r    <= hrpi_pkg::THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      prev_r      <= prev_nxt;
      peaks_r     <= peaks_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        thresh_r <= cfg_pwdata[hrpi_pkg::THRESH_W-1:0];
      end
    end
    beat_r <= beat_nxt;
    rate_r <= rate_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_beat_found = beat_r;
  assign out_rate_bpm   = rate_r;

endmodule

@@ tb/heart_rate_peak_interval_checker.sv @@
// ----------------------------------------------------------------------------
// heart_rate_peak_interval_checker: result predictor and scoreboard
// Watches the sample, result and configuration ports of the heart rate core.
// Every sample transfer runs through a local copy of the detector to give the
// expected beat report, and every result transfer is compared against the
// oldest report still waiting.
// ----------------------------------------------------------------------------
module heart_rate_peak_interval_checker #(
  parameter int SAMPLE_W = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [SAMPLE_W-1:0]         in_sample,
  input  logic [hrpi_pkg::TIME_W-1:0]        in_timestamp_ms,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               out_beat_found,
  input  logic [hrpi_pkg::RATE_W-1:0]        out_rate_bpm,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  input  logic                               cfg_pready,
  output int                                 mismatch_count,
  output int                                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        beat;
    logic [hrpi_pkg::RATE_W-1:0] bpm;
  } beat_report_t;

  // Reports still owed by the core, oldest first.
  beat_report_t beat_reports[$];

  // Local detector state.
  hrpi_pkg::phase_t                     det_phase;
  logic signed [SAMPLE_W-1:0]           prior_sample;
  logic                                 first_peak_held;
  logic [hrpi_pkg::TIME_W-1:0]          pair_start_ms;
  logic [hrpi_pkg::TIME_W-1:0]          pair_end_ms;
  logic signed [hrpi_pkg::THRESH_W-1:0] peak_level;
  int                                   report_index;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    report_index   = 0;
  end

  // Advances the detector by one sample and returns the report it produces.
  function automatic beat_report_t predict_beat(input logic signed [SAMPLE_W-1:0] s,
                                                input logic [hrpi_pkg::TIME_W-1:0] ts);
    beat_report_t                rpt;
    logic [hrpi_pkg::TIME_W-1:0] interval;
    logic [hrpi_pkg::TIME_W-1:0] bpm;
    rpt = '0;
    case (det_phase)
      hrpi_pkg::PH_PEAK: begin
        // A falling sample above the threshold marks a peak.
        if (int'(s) > int'(peak_level) && int'(s) < int'(prior_sample)) begin
          if (!first_peak_held) begin
            pair_start_ms   = ts;
            first_peak_held = 1'b1;
            det_phase       = hrpi_pkg::PH_ZERO_CROSS;
          end else begin
            pair_end_ms = ts;
            det_phase   = hrpi_pkg::PH_COMPUTE;
          end
        end
        prior_sample = s;
      end
      hrpi_pkg::PH_COMPUTE: begin
        // The sample itself is ignored; the interval wraps modulo 2^32.
        interval = pair_end_ms - pair_start_ms;
        if (interval != '0) begin
          bpm = hrpi_pkg::TIME_W'(hrpi_pkg::RATE_NUM) / interval;
          if (bpm > hrpi_pkg::TIME_W'(hrpi_pkg::RATE_LO_EXCL) &&
              bpm < hrpi_pkg::TIME_W'(hrpi_pkg::RATE_HI_EXCL)) begin
            rpt.beat = 1'b1;
            rpt.bpm  = bpm[hrpi_pkg::RATE_W-1:0];
          end
        end
        det_phase       = hrpi_pkg::PH_ZERO_CROSS;
        first_peak_held = 1'b1;
        prior_sample    = '0;
        pair_start_ms   = pair_end_ms;
      end
      default: begin
        // Upward zero crossing arms the peak search.
        if (int'(s) > 0 && int'(prior_sample) < 0) det_phase = hrpi_pkg::PH_PEAK;
        else det_phase = hrpi_pkg::PH_ZERO_CROSS;
        prior_sample = s;
      end
    endcase
    return rpt;
  endfunction

  always @(posedge clk) begin
    beat_report_t want;
    if (!rst_n) begin
      beat_reports.delete();
      det_phase       = hrpi_pkg::PH_ZERO_CROSS;
      prior_sample    = '0;
      first_peak_held = 1'b0;
      pair_start_ms   = '0;
      pair_end_ms     = '0;
      peak_level      = hrpi_pkg::THRESH_RESET;
    end else begin
      // Result transfer: compare against the oldest outstanding report.
      if (out_valid && !out_stall) begin
        report_index++;
        if (beat_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: no report expected, got beat=%0b bpm=%0d",
                     report_index, out_beat_found, out_rate_bpm);
        end else begin
          want = beat_reports.pop_front();
          if (out_beat_found !== want.beat || out_rate_bpm !== want.bpm) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected beat=%0b bpm=%0d, got beat=%0b bpm=%0d",
                       report_index, want.beat, want.bpm, out_beat_found, out_rate_bpm);
          end
        end
      end
      // Sample transfer: predict the report it causes.
      if (in_valid && !in_stall)
        beat_reports.push_back(predict_beat(in_sample, in_timestamp_ms));
      // Register write on the configuration port.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {hrpi_pkg::REG_PEAK_THRESHOLD, 2'b00})
        peak_level = cfg_pwdata[hrpi_pkg::THRESH_W-1:0];
    end
    pending_count = beat_reports.size();
  end

endmodule

@@ tb/heart_rate_peak_interval_core_test.sv @@
// ----------------------------------------------------------------------------
// heart_rate_peak_interval_core_test: stimulus and verdict for the rate core
// Drives a directed run through the rate limits, zero interval and timestamp
// wrap, then phases of random pulse trains and noise under several peak
// thresholds, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module heart_rate_peak_interval_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W      = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_sample       = '0;
  logic [hrpi_pkg::TIME_W-1:0] in_timestamp_ms = '0;
  logic                        out_valid;
  logic                        out_stall       = 1'b0;
  logic                        out_beat_found;
  logic [hrpi_pkg::RATE_W-1:0] out_rate_bpm;
  logic                        cfg_psel        = 1'b0;
  logic                        cfg_penable     = 1'b0;
  logic                        cfg_pwrite      = 1'b0;
  logic [2:0]                  cfg_paddr       = '0;
  logic [31:0]                 cfg_pwdata      = '0;
  logic [31:0]                 cfg_prdata;
  logic                        cfg_pready;

  int                          mismatch_count;
  int                          pending_count;
  int                          sent_items   = 0;
  int                          cur_thr      = 20;
  logic [hrpi_pkg::TIME_W-1:0] last_peak_ms = '0;
  logic                        calm         = 1'b0;
  logic                        hold_request = 1'b0;

  heart_rate_peak_interval_core #(.SAMPLE_WIDTH(SAMPLE_W)) dut (.*);

  heart_rate_peak_interval_checker #(.SAMPLE_W(SAMPLE_W)) beat_checker (.*);

  always #2 clk = ~clk;

  // Offers one sample, after an optional idle burst, and waits for its transfer.
  task automatic put_sample(input int s, input logic [hrpi_pkg::TIME_W-1:0] ts);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= SAMPLE_W'(s);
    in_timestamp_ms <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // Drops valid and waits until every report has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access cycle of a threshold write.
  task automatic write_threshold(input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {hrpi_pkg::REG_PEAK_THRESHOLD, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_thr = value;
  endtask

  // Short pulse at the reset threshold, followed by the compute item.
  task automatic directed_pair(input logic [hrpi_pkg::TIME_W-1:0] gap_ms);
    put_sample(-5, $urandom());
    put_sample(500, $urandom());
    put_sample(21, last_peak_ms + gap_ms);
    put_sample(0, $urandom());
    last_peak_ms = last_peak_ms + gap_ms;
  endtask

  // Mostly plausible heart periods, with the rate limits, zero and wrap mixed in.
  function automatic logic [hrpi_pkg::TIME_W-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: pick_interval = 0;
          1: pick_interval = 214;
          2: pick_interval = 215;
          3: pick_interval = 1935;
          4: pick_interval = 1936;
          default: pick_interval = 2000;
        endcase
      end
      1: pick_interval = $urandom_range(1, 214);
      2: pick_interval = $urandom();
      3: pick_interval = $urandom_range(2001, 70000);
      default: pick_interval = $urandom_range(215, 1935);
    endcase
  endfunction

  // Negative dip, rise through zero, then a fall above the threshold at peak_ts.
  task automatic send_pulse(input logic [hrpi_pkg::TIME_W-1:0] peak_ts);
    int lo;
    int top_v;
    int rise_v;
    put_sample(-int'($urandom_range(1, 32768)), $urandom());
    if (cur_thr >= 32766) begin
      // No falling sample can clear this threshold.
      put_sample($urandom_range(1, 32767), $urandom());
      put_sample($urandom_range(1, 32767), peak_ts);
    end else begin
      lo     = (cur_thr < 0) ? 1 : cur_thr + 1;
      top_v  = $urandom_range(lo + 1, 32767);
      rise_v = $urandom_range(1, top_v);
      put_sample(rise_v, $urandom());
      if (rise_v != top_v) put_sample(top_v, $urandom());
      put_sample($urandom_range(lo, top_v - 1), peak_ts);
    end
  endtask

  // Random mix of pulse trains, noise and broken pulses.
  task automatic run_random_phase(input int count);
    int                          target;
    int                          choice;
    logic [hrpi_pkg::TIME_W-1:0] next_peak;
    target = sent_items + count;
    while (sent_items < target) begin
      choice = $urandom_range(0, 9);
      if (choice <= 6) begin
        next_peak = last_peak_ms + pick_interval();
        send_pulse(next_peak);
        last_peak_ms = next_peak;
        // Becomes the compute item once a pair is held.
        put_sample(int'($urandom_range(0, 65535)) - 32768, $urandom());
      end else if (choice == 7) begin
        repeat ($urandom_range(1, 4))
          put_sample(int'($urandom_range(0, 65535)) - 32768, $urandom());
      end else if (choice == 8) begin
        repeat ($urandom_range(1, 6))
          put_sample(int'($urandom_range(0, 128)) - 64, $urandom());
      end else begin
        // A fall to exactly the threshold must not count as a peak.
        put_sample(-int'($urandom_range(1, 32768)), $urandom());
        put_sample(32767, $urandom());
        put_sample(cur_thr, $urandom());
      end
    end
  endtask

  // Result side: random stall bursts, quiet stretches and one long hold.
  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int thr;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and a first pair whose interval crosses the timestamp wrap.
    put_sample(32767, 32'h0000_0000);
    put_sample(-32768, 32'hFFFF_FFFF);
    put_sample(32767, 32'h1234_5678);
    put_sample(32766, 32'hFFFF_FF00);
    put_sample(-1, $urandom());
    put_sample(30000, $urandom());
    put_sample(21, 32'h0000_0064);
    put_sample(0, 32'h0000_0000);
    last_peak_ms = 32'h0000_0064;

    // Rate limits on both sides and a zero interval.
    directed_pair(215);
    directed_pair(214);
    directed_pair(1936);
    directed_pair(0);
    settle();

    // Random phases under different thresholds, extremes included.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: thr = -32768;
        1: thr = 32767;
        2: thr = 0;
        3: thr = int'($urandom_range(0, 65535)) - 32768;
        4: thr = 1000;
        default: thr = 20;
      endcase
      write_threshold(thr);
      if (p == 3) hold_request = 1'b1;
      if (p == 5) calm = 1'b1;
      run_random_phase((p == 1) ? 100 : 300);
      settle();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ heart_rate_peak_interval_core.f @@
sv/hrpi_pkg.sv
sv/hrpi_div.sv
sv/heart_rate_peak_interval_core.sv
tb/heart_rate_peak_interval_checker.sv
tb/heart_rate_peak_interval_core_test.sv
